>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the rtl, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/slid_pkg.sv
// ---------------------------------------------------------------------------
// slid_pkg
// Constants, codes and link types of the sorted table cell chain
// ---------------------------------------------------------------------------
package slid_pkg;

   // table geometry
   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   // operation codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // operation broadcast to every cell
   typedef struct packed {
      logic                   load;
      logic [1:0]             action;
      logic [VALUE_WIDTH-1:0] value;
   } slid_cmd_type;

   // what one cell shows its neighbours
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] entry;
      logic                   valid;
      logic                   lt;   // entry sits ahead of the new value
      logic                   hit;  // first match found here or further left
   } slid_link_type;

endpackage

>>> rtl/slid_cell.sv
// ---------------------------------------------------------------------------
// slid_cell
// One slot of the sorted table: holds an entry and shifts with neighbours
// ---------------------------------------------------------------------------
module slid_cell
   import slid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  slid_cmd_type  cmd,
   input  slid_link_type left_link,
   input  slid_link_type right_link,
   output slid_link_type this_link
);

   logic [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                   valid_ff, valid_in;
   logic                   lt, match;

   // local compares against the broadcast value
   assign lt    = valid_ff && ($signed(entry_ff) < $signed(cmd.value));
   assign match = valid_ff && (entry_ff == cmd.value);

   assign this_link.entry = entry_ff;
   assign this_link.valid = valid_ff;
   assign this_link.lt    = lt;
   assign this_link.hit   = left_link.hit | match;

   // next slot contents
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (cmd.action)
         ACT_INSERT: begin
            if (!lt) begin
               if (left_link.lt) begin
                  entry_in = cmd.value;
                  valid_in = 1'b1;
               end else begin
                  entry_in = left_link.entry;
                  valid_in = left_link.valid;
               end
            end
         end
         ACT_DELETE: begin
            if (left_link.hit || match) begin
               entry_in = right_link.entry;
               valid_in = right_link.valid;
            end
         end
         ACT_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // valid bit under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load) begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         entry_ff <= entry_in;
      end
   end

endmodule

>>> rtl/sorted_list_insert_delete_unit.sv
// ---------------------------------------------------------------------------
// sorted_list_insert_delete_unit
// Bounded ascending table of signed values built as a chain of cells
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one beat per operation, tuser carries the action code
//   (insert, delete first equal, clear), tdata the value.
//   rsp channel: one beat per operation with status in tuser and the entry
//   count, smallest-valid flag and smallest entry in tdata.
//   Every cell compares its entry with the broadcast value and takes its
//   own, the new value or a neighbour's entry, so an operation completes
//   in the cycle it is accepted; the result is presented on the next cycle
//   and one beat per cycle is sustained while rsp_tready stays high.
//   The delete match ripples left to right through the whole chain of
//   cells; the compare followed by that ripple sets the cycle time.
//   A pending result holds rsp_tvalid; req_tready is low while it waits and
//   the receiver stalls, and rises again in the cycle it is taken.
//   Reset empties the table at once (valid bits and count clear); no
//   clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_list_insert_delete_unit
   import slid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] value, [39:32] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] entry_count, [5] smallest_valid,
                                    // [37:6] smallest, [39:38] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic                   accept;
   logic                   full, found;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   slid_cmd_type           cmd;
   slid_link_type          links [CAPACITY];
   slid_link_type          head_link, tail_link;

   // handshake: take a beat when no result is left waiting
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = links[CAPACITY-1].valid;
   assign found = links[CAPACITY-1].hit;

   // broadcast command, a full-table insert leaves the cells alone
   always_comb begin
      cmd.action = req_tuser;
      cmd.value  = req_tdata[VALUE_WIDTH-1:0];
      cmd.load   = accept && !((req_tuser == ACT_INSERT) && full);
   end

   // boundaries of the chain
   always_comb begin
      head_link.entry = '0;
      head_link.valid = 1'b1;
      head_link.lt    = 1'b1;
      head_link.hit   = 1'b0;
      tail_link.entry = '0;
      tail_link.valid = 1'b0;
      tail_link.lt    = 1'b0;
      tail_link.hit   = 1'b0;
   end

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slid_link_type left_sel, right_sel;
      if (i == 0) begin : g_first
         assign left_sel = head_link;
      end else begin : g_mid
         assign left_sel = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_sel = tail_link;
      end else begin : g_inner
         assign right_sel = links[i+1];
      end
      slid_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (left_sel),
         .right_link (right_sel),
         .this_link  (links[i])
      );
   end

   // status and count of the accepted beat
   always_comb begin
      status_in = ST_DONE;
      count_in  = count_ff;
      case (req_tuser)
         ACT_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         ACT_DELETE: begin
            if (found) begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= ST_DONE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff  <= count_in;
            status_ff <= status_in;
         end
      end
   end

   // result beat straight from the table state
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00,
                        links[0].valid ? 32'(links[0].entry) : 32'd0,
                        links[0].valid,
                        5'(count_ff)};

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_WIDTH'(CAPACITY))
   `ASSERT_ALWAYS(a_head_matches_count, clock, reset,
                  links[0].valid == (count_ff != '0))
   `ASSERT_ALWAYS(a_tail_matches_count, clock, reset,
                  links[CAPACITY-1].valid == (count_ff == COUNT_WIDTH'(CAPACITY)))
   `ASSERT_NEXT(a_insert_grows, clock, reset,
                accept && (req_tuser == ACT_INSERT) && !full,
                count_ff == $past(count_ff) + COUNT_WIDTH'(1))

endmodule
